// ----- hw/rtl/pwft_pkg.sv -----
package pwft_pkg;

   // Field widths of the streams and the register port.
   localparam int TimeWidth  = 16;
   localparam int KindWidth  = 3;
   localparam int CountWidth = 6;
   localparam int IndexWidth = 2;

   // Pulse kinds as they travel on the result stream.
   localparam logic [KindWidth-1:0] KIND_PREAMBLE = 3'd0;
   localparam logic [KindWidth-1:0] KIND_START    = 3'd1;
   localparam logic [KindWidth-1:0] KIND_ZERO     = 3'd2;
   localparam logic [KindWidth-1:0] KIND_ONE      = 3'd3;
   localparam logic [KindWidth-1:0] KIND_STOP     = 3'd4;

   // Register indexes on the register write port.
   localparam logic [IndexWidth-1:0] REG_SHORT_TIME     = 2'd0;
   localparam logic [IndexWidth-1:0] REG_LONG_TIME      = 2'd1;
   localparam logic [IndexWidth-1:0] REG_FRAME_TIME     = 2'd2;
   localparam logic [IndexWidth-1:0] REG_PREAMBLE_COUNT = 2'd3;

   // Register reset values.
   localparam logic [TimeWidth-1:0]  SHORT_TIME_RESET     = 16'd68;
   localparam logic [TimeWidth-1:0]  LONG_TIME_RESET      = 16'd136;
   localparam logic [TimeWidth-1:0]  FRAME_TIME_RESET     = 16'd272;
   localparam logic [CountWidth-1:0] PREAMBLE_COUNT_RESET = 6'd32;

   // Largest preamble that is sent, and the number of bit pulses per byte.
   localparam logic [CountWidth-1:0] MAX_PREAMBLE = 6'd32;
   localparam logic [CountWidth-1:0] BITS_PER_BYTE = 6'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load_item;  // capture the accepted word
      logic                 load_bits;  // pulse counter gets the bit count
      logic                 count_down; // pulse counter steps down
      logic                 shift;      // next data bit to the top
      logic                 emit;       // write one pulse into the output register
      logic [KindWidth-1:0] kind;       // kind of the pulse written
      logic                 last;       // pulse closes the current word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;     // output register can take a pulse this cycle
      logic pre_zero;     // configured preamble is empty
      logic count_one;    // pulse counter is at its final step
      logic bit_msb;      // data bit that is sent next
      logic item_last;    // captured word closes a frame
   } status_type;

endpackage

// ----- hw/rtl/pulse_width_frame_transmitter_top.sv -----
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tdata: data_byte; tuser: first_of_frame;
//                                              tlast: last_of_frame
// rsp       out        rsp_tvalid/rsp_tready   tdata: high_time, low_time;
//                                              tuser: pulse_kind; tlast: last_pulse
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// A word is accepted while idle, then one pulse leaves per cycle through the output
// register while rsp_tready does not stall it: eight bit pulses for a plain byte, one
// more with a stop pulse, and n + 1 more for a frame opener with a preamble of n pulses.
// The output register lets the last pulse of one word wait while the next word is taken.
// A stalled rsp_tready holds the pulse sequencer; reset is synchronous, active high,
// and restores the register defaults.
module pulse_width_frame_transmitter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tuser,   // [0] first_of_frame
   input  logic                            req_tlast,   // last_of_frame
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [15:0] high_time, [31:16] low_time
   output logic [pwft_pkg::KindWidth-1:0]  rsp_tuser,   // [2:0] pulse_kind
   output logic                            rsp_tlast,   // last_pulse
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pwft_pkg::IndexWidth-1:0] csr_index,
   input  logic [pwft_pkg::TimeWidth-1:0]  csr_data
);
   import pwft_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [TimeWidth-1:0] high_time;
   logic [TimeWidth-1:0] low_time;

   // Sequencer for preamble, start, bit and stop pulses.
   pwft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_first  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Registers, captured word, pulse counter and output register.
   pwft_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_data_byte (req_tdata),
      .req_first     (req_tuser),
      .req_last      (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_high_time (high_time),
      .rsp_low_time  (low_time),
      .rsp_kind      (rsp_tuser),
      .rsp_last      (rsp_tlast),
      .cmd           (cmd),
      .status        (status)
   );

   assign rsp_tdata = {low_time, high_time};

endmodule

// ----- hw/rtl/pwft_ctrl.sv -----
module pwft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_first,
   output logic                 req_tready,
   input  pwft_pkg::status_type status,
   output pwft_pkg::cmd_type    cmd
);
   import pwft_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRE   = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_BITS  = 3'd3;
   localparam logic [2:0] ST_STOP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands; every pulse waits for room in the output register.
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.kind       = KIND_PREAMBLE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               if (!req_first) begin
                  state_in = ST_BITS;
               end else if (status.pre_zero) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_PRE;
               end
            end
         end
         ST_PRE: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = KIND_PREAMBLE;
               cmd.count_down = 1'b1;
               if (status.count_one) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.kind      = KIND_START;
               cmd.load_bits = 1'b1;
               state_in      = ST_BITS;
            end
         end
         ST_BITS: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = status.bit_msb ? KIND_ONE : KIND_ZERO;
               cmd.shift      = 1'b1;
               cmd.count_down = 1'b1;
               cmd.last       = status.count_one & ~status.item_last;
               if (status.count_one) begin
                  state_in = status.item_last ? ST_STOP : ST_IDLE;
               end
            end
         end
         ST_STOP: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_STOP;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/pwft_datapath.sv -----
module pwft_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pwft_pkg::IndexWidth-1:0]       csr_index,
   input  logic [pwft_pkg::TimeWidth-1:0]        csr_data,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_first,
   input  logic                                  req_last,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pwft_pkg::TimeWidth-1:0]        rsp_high_time,
   output logic [pwft_pkg::TimeWidth-1:0]        rsp_low_time,
   output logic [pwft_pkg::KindWidth-1:0]        rsp_kind,
   output logic                                  rsp_last,
   input  pwft_pkg::cmd_type                     cmd,
   output pwft_pkg::status_type                  status
);
   import pwft_pkg::*;

   logic [TimeWidth-1:0]  short_time_ff;
   logic [TimeWidth-1:0]  long_time_ff;
   logic [TimeWidth-1:0]  frame_time_ff;
   logic [CountWidth-1:0] preamble_count_ff;
   logic [CountWidth-1:0] preamble_sat;

   logic [7:0]            byte_ff;
   logic [7:0]            byte_in;
   logic                  last_ff;
   logic                  last_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic                  valid_ff;
   logic                  valid_in;
   logic [TimeWidth-1:0]  high_ff;
   logic [TimeWidth-1:0]  high_in;
   logic [TimeWidth-1:0]  low_ff;
   logic [TimeWidth-1:0]  low_in;
   logic [KindWidth-1:0]  kind_ff;
   logic                  rlast_ff;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_time_ff     <= SHORT_TIME_RESET;
         long_time_ff      <= LONG_TIME_RESET;
         frame_time_ff     <= FRAME_TIME_RESET;
         preamble_count_ff <= PREAMBLE_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SHORT_TIME:     short_time_ff     <= csr_data;
            REG_LONG_TIME:      long_time_ff      <= csr_data;
            REG_FRAME_TIME:     frame_time_ff     <= csr_data;
            REG_PREAMBLE_COUNT: preamble_count_ff <= csr_data[CountWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // Preamble lengths above the maximum are clamped.
   assign preamble_sat = (preamble_count_ff > MAX_PREAMBLE) ? MAX_PREAMBLE
                                                            : preamble_count_ff;

   // Captured word and the pulse counter for preamble and bits.
   always_comb begin
      byte_in  = byte_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (cmd.load_item) begin
         byte_in  = req_data_byte;
         last_in  = req_last;
         count_in = req_first ? preamble_sat : BITS_PER_BYTE;
      end else begin
         if (cmd.shift) begin
            byte_in = {byte_ff[6:0], 1'b0};
         end
         if (cmd.load_bits) begin
            count_in = BITS_PER_BYTE;
         end else if (cmd.count_down) begin
            count_in = count_ff - CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   // Pulse times by kind.
   always_comb begin
      case (cmd.kind)
         KIND_PREAMBLE: begin
            high_in = short_time_ff;
            low_in  = short_time_ff;
         end
         KIND_START: begin
            high_in = frame_time_ff;
            low_in  = frame_time_ff;
         end
         KIND_ONE: begin
            high_in = long_time_ff;
            low_in  = short_time_ff;
         end
         KIND_STOP: begin
            high_in = frame_time_ff;
            low_in  = '0;
         end
         default: begin
            high_in = short_time_ff;
            low_in  = short_time_ff;
         end
      endcase
   end

   // Output register; a waiting pulse is released by rsp_tready.
   assign valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         high_ff  <= high_in;
         low_ff   <= low_in;
         kind_ff  <= cmd.kind;
         rlast_ff <= cmd.last;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_high_time = high_ff;
   assign rsp_low_time  = low_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_last      = rlast_ff;

   // Status back to the controller.
   assign status.out_free  = ~valid_ff | rsp_tready;
   assign status.pre_zero  = (preamble_sat == '0);
   assign status.count_one = (count_ff == CountWidth'(1));
   assign status.bit_msb   = byte_ff[7];
   assign status.item_last = last_ff;

endmodule
